// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and register codes for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_METHOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN  = 3'd4;

  localparam logic METHOD_SET = 1'b0;
  localparam logic METHOD_STR = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } qent_t;

  typedef struct packed {
    logic tail;
    logic upd;
  } win_ctl_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic offs;
  } q_ctl_t;

endpackage

// File: hw/rtl/sfr_win_cell.sv
// ----------------------------------------------------------------------------
// sfr_win_cell
// One window cell: holds a pending byte and compares it (or the input byte,
// when the cell is the tail) against every pattern byte.
// ----------------------------------------------------------------------------
module sfr_win_cell #(
  parameter int P = 8
) (
  input  logic            clk,
  input  sfr_pkg::win_ctl_t ctl_i,
  input  logic [7:0]      in_byte_i,
  input  logic [7:0]      nxt_i,
  input  logic [8*P-1:0]  pat_i,
  output logic [7:0]      ext_o,
  output logic [P-1:0]    eq_o
);
  import sfr_pkg::*;

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctl_i.upd) begin
      byte_r <= nxt_i;
    end
  end

  assign ext_o = ctl_i.tail ? in_byte_i : byte_r;

  always_comb begin
    for (int j = 0; j < P; j++) begin
      eq_o[j] = (ext_o == pat_i[8*j +: 8]);
    end
  end

endmodule

// File: hw/rtl/sfr_q_cell.sv
// ----------------------------------------------------------------------------
// sfr_q_cell
// One result queue cell: loads a new result, takes its neighbor's on a pop,
// or holds.
// ----------------------------------------------------------------------------
module sfr_q_cell (
  input  logic           clk,
  input  sfr_pkg::q_ctl_t ctl_i,
  input  sfr_pkg::qent_t nb_i,
  input  sfr_pkg::qent_t lo_i,
  input  sfr_pkg::qent_t hi_i,
  output sfr_pkg::qent_t q_o
);
  import sfr_pkg::*;

  qent_t q_r;

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      q_r <= ctl_i.offs ? hi_i : lo_i;
    end else if (ctl_i.shift) begin
      q_r <= nb_i;
    end
  end

  assign q_o = q_r;

endmodule

// File: hw/rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte stream rewriter: replaces set bytes or pattern occurrences by a word.
// The results of an accepted item are registered into the result queue.
// Throughput: one item per cycle while out_stall is low and each item
//   yields at most one result; an item with n results occupies the single
//   output port until all n are popped. Reset: synchronous active-low;
//   empties the window and the result queue and loads the register defaults.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_WORD_BYTES    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_has_byte,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfr_pkg::*;

  localparam int P   = MAX_PATTERN_BYTES;
  localparam int W   = MAX_WORD_BYTES;
  localparam int N   = (P > W) ? P : W;
  localparam int QD  = N + 1;
  localparam int CW  = $clog2(P + 1);
  localparam int WLW = $clog2(W + 1);
  localparam int NW  = $clog2(N + 1);
  localparam int QCW = $clog2(QD + 1);

  logic           method_r;
  logic [8*P-1:0] pat_r;
  logic [3:0]     pat_len_r;
  logic [8*W-1:0] word_r;
  logic [3:0]     word_len_r;
  logic           cfg_known;

  logic [CW-1:0]  win_cnt_r, win_cnt_nxt;
  logic [QCW-1:0] q_cnt_r, q_cnt_nxt;

  win_ctl_t       win_ctl [P];
  logic [7:0]     win_nxt [P];
  logic [7:0]     ext     [P];
  logic [P-1:0]   eq      [P];
  logic [8*P-1:0] ext_flat;
  logic [8*P-1:0] ext_shift;
  logic [7:0]     ext_pad [N];
  logic [8*N-1:0] word_pad;

  logic [P-1:0]   m;
  logic [CW-1:0]  win_len;
  logic [CW-1:0]  sel;
  logic [CW-1:0]  pl_set, pl_str;
  logic [WLW-1:0] wl;
  logic           full, hit, use_word, bare;
  logic [NW-1:0]  n, n_fin;
  qent_t          ent [N];

  logic           pop, accept;
  logic [QCW-1:0] cnt_pop;
  q_ctl_t         q_ctl [QD];
  qent_t          q     [QD];
  qent_t          q_nb  [QD];
  qent_t          q_lo  [QD];
  qent_t          q_hi  [QD];

  assign cfg_known = cfg_we && (cfg_index inside {[REG_METHOD:REG_WORD_LEN]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r   <= METHOD_SET;
      pat_r      <= '0;
      pat_len_r  <= 4'd1;
      word_r     <= '0;
      word_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METHOD:     method_r   <= cfg_wdata[0];
        REG_PAT_BYTES:  pat_r      <= cfg_wdata[8*P-1:0];
        REG_PAT_LEN:    pat_len_r  <= cfg_wdata[3:0];
        REG_WORD_BYTES: word_r     <= cfg_wdata[8*W-1:0];
        REG_WORD_LEN:   word_len_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign pop      = out_valid && !out_stall;
  assign cnt_pop  = q_cnt_r - QCW'(pop);
  assign in_stall = (cnt_pop > QCW'(1));
  assign accept   = in_valid && !in_stall;

  // pending window
  for (genvar i = 0; i < P; i++) begin : g_win
    assign win_ctl[i].tail = (win_cnt_r == CW'(i));
    assign win_ctl[i].upd  = accept && (method_r == METHOD_STR);
    assign ext_flat[8*i +: 8] = ext[i];
    assign win_nxt[i] = ext_shift[8*i +: 8];

    sfr_win_cell #(.P(P)) u_win (
      .clk       (clk),
      .ctl_i     (win_ctl[i]),
      .in_byte_i (in_byte),
      .nxt_i     (win_nxt[i]),
      .pat_i     (pat_r),
      .ext_o     (ext[i]),
      .eq_o      (eq[i])
    );
  end

  for (genvar k = 0; k < N; k++) begin : g_pad
    if (k < P) begin : g_e
      assign ext_pad[k] = ext[k];
    end else begin : g_z
      assign ext_pad[k] = '0;
    end
  end

  assign word_pad  = (8*N)'(word_r);
  assign ext_shift = ext_flat >> {sel, 3'b000};

  always_comb begin
    pl_set  = (pat_len_r > 4'(P)) ? CW'(P) : pat_len_r[CW-1:0];
    pl_str  = (pl_set == '0) ? CW'(1) : pl_set;
    wl      = (word_len_r > 4'(W)) ? WLW'(W) : word_len_r[WLW-1:0];
    win_len = win_cnt_r + CW'(1);

    for (int s = 0; s < P; s++) begin
      m[s] = 1'b1;
      for (int i = 0; i < P - s; i++) begin
        if (CW'(s + i) < win_len) begin
          m[s] = m[s] & eq[s+i][i];
        end
      end
    end

    sel = win_len;
    for (int s = P - 1; s >= 0; s--) begin
      if ((CW'(s) < win_len) && m[s]) begin
        sel = CW'(s);
      end
    end

    full = (sel == '0) && (win_len == pl_str);

    hit = 1'b0;
    for (int j = 0; j < P; j++) begin
      if ((CW'(j) < pl_set) && eq[0][j]) begin
        hit = 1'b1;
      end
    end

    use_word = (method_r == METHOD_STR) ? full : hit;
    if (use_word) begin
      n = NW'(wl);
    end else if (method_r == METHOD_SET) begin
      n = NW'(1);
    end else if (in_last) begin
      n = NW'(win_len);
    end else begin
      n = NW'(sel);
    end
    bare  = in_last && (n == '0);
    n_fin = bare ? NW'(1) : n;

    for (int k = 0; k < N; k++) begin
      ent[k].data     = bare ? 8'h00 : (use_word ? word_pad[8*k +: 8] : ext_pad[k]);
      ent[k].has_byte = !bare;
      ent[k].last     = in_last && (NW'(k) == n_fin - NW'(1));
    end

    if (cfg_known) begin
      win_cnt_nxt = '0;
    end else if (accept && (method_r == METHOD_STR)) begin
      win_cnt_nxt = (in_last || full) ? '0 : (win_len - sel);
    end else begin
      win_cnt_nxt = win_cnt_r;
    end

    q_cnt_nxt = cnt_pop + (accept ? QCW'(n_fin) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
      q_cnt_r   <= '0;
    end else begin
      win_cnt_r <= win_cnt_nxt;
      q_cnt_r   <= q_cnt_nxt;
    end
  end

  // result queue
  for (genvar k = 0; k < QD; k++) begin : g_q
    if (k < N) begin : g_lo
      assign q_lo[k] = ent[k];
    end else begin : g_lz
      assign q_lo[k] = '0;
    end
    if (k > 0) begin : g_hi
      assign q_hi[k] = ent[k-1];
    end else begin : g_hz
      assign q_hi[k] = '0;
    end
    if (k < QD - 1) begin : g_nb
      assign q_nb[k] = q[k+1];
    end else begin : g_nz
      assign q_nb[k] = '0;
    end

    assign q_ctl[k].shift = pop;
    assign q_ctl[k].load  = accept && (QCW'(k) >= cnt_pop)
                            && (QCW'(k) < cnt_pop + QCW'(n_fin));
    assign q_ctl[k].offs  = cnt_pop[0];

    sfr_q_cell u_q (
      .clk   (clk),
      .ctl_i (q_ctl[k]),
      .nb_i  (q_nb[k]),
      .lo_i  (q_lo[k]),
      .hi_i  (q_hi[k]),
      .q_o   (q[k])
    );
  end

  assign out_valid    = (q_cnt_r != '0);
  assign out_byte     = q[0].data;
  assign out_has_byte = q[0].has_byte;
  assign out_last     = q[0].last;

endmodule

// File: hw/rtl/sfr_chk.sv
// ----------------------------------------------------------------------------
// sfr_chk
// Port-level checks for the stream find-and-replace block.
// ----------------------------------------------------------------------------
module sfr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("results present after reset");

  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> (out_last && (out_byte == 8'h00)))
    else $error("bare result is not a clean end marker");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
      && $stable(out_has_byte) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind stream_find_and_replace sfr_chk u_sfr_chk (.*);
